// ===== rtl/mmlx_pkg.sv =====
// ----------------------------------------------------------------------------
// MML lexer package
// Shared widths, token kind codes, character codes, payload structs and the
// single-character classification table.
// ----------------------------------------------------------------------------
package mmlx_pkg;

	// Default accumulator width for number tokens
	localparam int VALUE_WIDTH_DEF = 16;

	localparam int KIND_W   = 5;
	localparam int LETTER_W = 3;
	localparam int NUM_W    = 16;

	// Token kinds
	localparam logic [KIND_W-1:0] TK_NOTE   = 5'd0;
	localparam logic [KIND_W-1:0] TK_REST   = 5'd1;
	localparam logic [KIND_W-1:0] TK_OCTAVE = 5'd2;
	localparam logic [KIND_W-1:0] TK_TEMPO  = 5'd3;
	localparam logic [KIND_W-1:0] TK_LENGTH = 5'd4;
	localparam logic [KIND_W-1:0] TK_VOLUME = 5'd5;
	localparam logic [KIND_W-1:0] TK_INSTR  = 5'd6;
	localparam logic [KIND_W-1:0] TK_SHARP  = 5'd7;
	localparam logic [KIND_W-1:0] TK_FLAT   = 5'd8;
	localparam logic [KIND_W-1:0] TK_DOT    = 5'd9;
	localparam logic [KIND_W-1:0] TK_TIE    = 5'd10;
	localparam logic [KIND_W-1:0] TK_UP     = 5'd11;
	localparam logic [KIND_W-1:0] TK_DOWN   = 5'd12;
	localparam logic [KIND_W-1:0] TK_LOOPS  = 5'd13;
	localparam logic [KIND_W-1:0] TK_LOOPE  = 5'd14;
	localparam logic [KIND_W-1:0] TK_NUMBER = 5'd15;
	localparam logic [KIND_W-1:0] TK_END    = 5'd16;
	localparam logic [KIND_W-1:0] TK_NONE   = 5'd31;

	// Character codes (Latin-1)
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_RBRK  = 8'h5D;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_G     = 8'h67;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_O     = 8'h6F;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_V     = 8'h76;
	localparam logic [7:0] CASE_OFS = 8'd32;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_text;
	} item_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [LETTER_W-1:0] letter;
		logic [NUM_W-1:0]    value;
		logic                sat;
		logic                last;
	} token_t;

	// Up to two tokens produced by one input item
	typedef struct packed {
		logic [1:0] cnt;
		token_t     tok0;
		token_t     tok1;
	} pair_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [LETTER_W-1:0] letter;
	} class_t;

	// Map one character to a single-character token kind, or TK_NONE
	function automatic class_t classify(input logic [7:0] c);
		logic [7:0] l;
		class_t     r;
		l = (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_OFS : c;
		r.kind   = TK_NONE;
		r.letter = '0;
		if (l >= CH_A && l <= CH_G) begin
			r.kind   = TK_NOTE;
			r.letter = LETTER_W'(l - CH_A);
		end else begin
			case (l)
				CH_R:     r.kind = TK_REST;
				CH_O:     r.kind = TK_OCTAVE;
				CH_T:     r.kind = TK_TEMPO;
				CH_L:     r.kind = TK_LENGTH;
				CH_V:     r.kind = TK_VOLUME;
				CH_AT:    r.kind = TK_INSTR;
				CH_PLUS:  r.kind = TK_SHARP;
				CH_HASH:  r.kind = TK_SHARP;
				CH_MINUS: r.kind = TK_FLAT;
				CH_DOT:   r.kind = TK_DOT;
				CH_AMP:   r.kind = TK_TIE;
				CH_GT:    r.kind = TK_UP;
				CH_LT:    r.kind = TK_DOWN;
				CH_LBRK:  r.kind = TK_LOOPS;
				CH_RBRK:  r.kind = TK_LOOPE;
				default:  r.kind = TK_NONE;
			endcase
		end
		return r;
	endfunction

endpackage

// ===== rtl/mmlx_ifs.sv =====
// ----------------------------------------------------------------------------
// MML lexer stream interfaces
// Valid/ready channels for input characters and output tokens.
// ----------------------------------------------------------------------------
interface mmlx_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_text;

	modport source (output valid, char_code, end_of_text, input ready);
	modport sink (input valid, char_code, end_of_text, output ready);
endinterface

interface mmlx_tok_if;
	logic                               valid;
	logic                               ready;
	logic [mmlx_pkg::KIND_W-1:0]        token_kind;
	logic [mmlx_pkg::LETTER_W-1:0]      note_letter;
	logic [mmlx_pkg::NUM_W-1:0]         number_value;
	logic                               number_saturated;
	logic                               last_of_run;

	modport source (output valid, token_kind, note_letter, number_value,
		number_saturated, last_of_run, input ready);
	modport sink (input valid, token_kind, note_letter, number_value,
		number_saturated, last_of_run, output ready);
endinterface

// ===== rtl/mmlx_in_reg.sv =====
// ----------------------------------------------------------------------------
// MML lexer input register
// Registers one character item; frees itself when the lexer takes the item.
// ----------------------------------------------------------------------------
module mmlx_in_reg (
	input  logic            clk,
	input  logic            arst_n,
	mmlx_char_if.sink       text,
	input  logic            take,
	output logic            item_valid,
	output mmlx_pkg::item_t item
);

	logic            valid_s1;
	mmlx_pkg::item_t item_s1;
	logic            xfer;

	// Accept when empty or when the held item leaves this cycle
	assign text.ready = !valid_s1 || take;
	assign xfer       = text.valid && text.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (xfer) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture payload on transfer
	always_ff @(posedge clk) begin
		if (xfer) begin
			item_s1.char_code   <= text.char_code;
			item_s1.end_of_text <= text.end_of_text;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

// ===== rtl/mmlx_lex.sv =====
// ----------------------------------------------------------------------------
// MML lexer scan core
// Holds the scan state and digit accumulator, and turns one registered
// character into zero, one or two tokens in a single pass.
// ----------------------------------------------------------------------------
module mmlx_lex #(
	parameter int VALUE_WIDTH = mmlx_pkg::VALUE_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  mmlx_pkg::item_t item,
	output logic            item_take,
	input  logic            pair_free,
	output logic            pair_load,
	output mmlx_pkg::pair_t pair
);

	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_SLASH  = 2'd1;
	localparam logic [1:0] MODE_LINE   = 2'd2;
	localparam logic [1:0] MODE_BLOCK  = 2'd3;

	localparam logic [VALUE_WIDTH-1:0] VMAX = '1;

	logic [1:0]             mode_q;
	logic [VALUE_WIDTH-1:0] acc_q;
	logic                   pend_q;
	logic                   ovf_q;
	logic [7:0]             held_q;
	logic                   held_vld_q;

	logic [7:0]             c;
	logic                   eot;
	logic                   lp_en;
	logic [7:0]             c_sel;
	logic                   is_dig;
	logic [3:0]             digit;
	logic [VALUE_WIDTH+3:0] acc_ext;
	logic [VALUE_WIDTH+3:0] prod;
	logic                   over;
	mmlx_pkg::class_t       cls;
	logic                   slash_flush;
	logic [VALUE_WIDTH-1:0] post_acc;
	logic                   post_ovf;
	logic                   post_pend;
	mmlx_pkg::token_t       cand [4];
	logic [3:0]             cv;
	logic [1:0]             n;
	mmlx_pkg::token_t       t0;
	mmlx_pkg::token_t       t1;

	// Build a number token from an accumulator value
	function automatic mmlx_pkg::token_t num_tok(input logic [VALUE_WIDTH-1:0] a,
		input logic s);
		logic [VALUE_WIDTH+mmlx_pkg::NUM_W-1:0] ext;
		mmlx_pkg::token_t t;
		ext      = {{mmlx_pkg::NUM_W{1'b0}}, a};
		t.kind   = mmlx_pkg::TK_NUMBER;
		t.letter = '0;
		t.value  = ext[mmlx_pkg::NUM_W-1:0];
		t.sat    = s;
		t.last   = 1'b0;
		return t;
	endfunction

	assign c   = item.char_code;
	assign eot = item.end_of_text;

	// Select the character that goes through plain lexing
	always_comb begin
		c_sel = eot ? held_q : c;
		if (eot) begin
			lp_en = (mode_q == MODE_BLOCK) && held_vld_q && (held_q != mmlx_pkg::CH_SLASH);
		end else begin
			lp_en = ((mode_q == MODE_NORMAL) && (c != mmlx_pkg::CH_SLASH)) ||
				((mode_q == MODE_SLASH) && (c != mmlx_pkg::CH_SLASH) &&
				(c != mmlx_pkg::CH_STAR));
		end
		slash_flush = !eot && (mode_q == MODE_NORMAL) && (c == mmlx_pkg::CH_SLASH);
	end

	// Digit accumulate: acc*10 + digit, saturating
	always_comb begin
		is_dig  = (c_sel >= mmlx_pkg::CH_ZERO) && (c_sel <= mmlx_pkg::CH_NINE);
		digit   = 4'(c_sel - mmlx_pkg::CH_ZERO);
		acc_ext = {4'b0, acc_q};
		prod    = (acc_ext << 3) + (acc_ext << 1) + (VALUE_WIDTH+4)'(digit);
		over    = prod > {4'b0, VMAX};
		cls     = mmlx_pkg::classify(c_sel);
	end

	// Accumulator after plain lexing
	always_comb begin
		post_acc  = acc_q;
		post_ovf  = ovf_q;
		post_pend = pend_q;
		if (lp_en && is_dig) begin
			post_acc  = over ? VMAX : prod[VALUE_WIDTH-1:0];
			post_ovf  = ovf_q | over;
			post_pend = 1'b1;
		end else if (lp_en) begin
			post_acc  = '0;
			post_ovf  = 1'b0;
			post_pend = 1'b0;
		end
	end

	// Candidate tokens in emission order, then keep the first two
	always_comb begin
		cand[0]        = num_tok(acc_q, ovf_q);
		cv[0]          = ((lp_en && !is_dig) || slash_flush) && pend_q;
		cand[1].kind   = cls.kind;
		cand[1].letter = cls.letter;
		cand[1].value  = '0;
		cand[1].sat    = 1'b0;
		cand[1].last   = 1'b0;
		cv[1]          = lp_en && !is_dig && (cls.kind != mmlx_pkg::TK_NONE);
		cand[2]        = num_tok(post_acc, post_ovf);
		cv[2]          = eot && post_pend;
		cand[3].kind   = mmlx_pkg::TK_END;
		cand[3].letter = '0;
		cand[3].value  = '0;
		cand[3].sat    = 1'b0;
		cand[3].last   = 1'b0;
		cv[3]          = eot;

		n  = 2'd0;
		t0 = cand[3];
		t1 = cand[3];
		for (int i = 0; i < 4; i++) begin
			if (cv[i] && (n != 2'd2)) begin
				if (n == 2'd0) begin
					t0 = cand[i];
				end else begin
					t1 = cand[i];
				end
				n = n + 2'd1;
			end
		end
		if (n == 2'd1) begin
			t0.last = 1'b1;
		end
		if (n == 2'd2) begin
			t1.last = 1'b1;
		end
	end

	// Items without tokens never wait on the output buffer
	assign item_take = item_valid && ((n == 2'd0) || pair_free);
	assign pair_load = item_valid && (n != 2'd0) && pair_free;
	assign pair.cnt  = n;
	assign pair.tok0 = t0;
	assign pair.tok1 = t1;

	// Advance scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_NORMAL;
			acc_q      <= '0;
			pend_q     <= 1'b0;
			ovf_q      <= 1'b0;
			held_q     <= '0;
			held_vld_q <= 1'b0;
		end else if (item_take) begin
			if (eot) begin
				mode_q     <= MODE_NORMAL;
				acc_q      <= '0;
				pend_q     <= 1'b0;
				ovf_q      <= 1'b0;
				held_q     <= '0;
				held_vld_q <= 1'b0;
			end else begin
				case (mode_q)
					MODE_SLASH: begin
						if (c == mmlx_pkg::CH_SLASH) begin
							mode_q <= MODE_LINE;
						end else if (c == mmlx_pkg::CH_STAR) begin
							mode_q     <= MODE_BLOCK;
							held_q     <= '0;
							held_vld_q <= 1'b0;
						end else begin
							mode_q <= MODE_NORMAL;
							acc_q  <= post_acc;
							ovf_q  <= post_ovf;
							pend_q <= post_pend;
						end
					end
					MODE_LINE: begin
						if (c == mmlx_pkg::CH_NL) begin
							mode_q <= MODE_NORMAL;
						end
					end
					MODE_BLOCK: begin
						if (held_vld_q && (held_q == mmlx_pkg::CH_STAR) &&
							(c == mmlx_pkg::CH_SLASH)) begin
							mode_q     <= MODE_NORMAL;
							held_q     <= '0;
							held_vld_q <= 1'b0;
						end else begin
							held_q     <= c;
							held_vld_q <= 1'b1;
						end
					end
					default: begin
						if (c == mmlx_pkg::CH_SLASH) begin
							mode_q <= MODE_SLASH;
							acc_q  <= '0;
							ovf_q  <= 1'b0;
							pend_q <= 1'b0;
						end else begin
							mode_q <= MODE_NORMAL;
							acc_q  <= post_acc;
							ovf_q  <= post_ovf;
							pend_q <= post_pend;
						end
					end
				endcase
			end
		end
	end

	// End of text returns the scanner to its reset state
	a_eot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		item_take && eot |=> (mode_q == MODE_NORMAL) && !pend_q && !held_vld_q)
		else $error("scan state not cleared after end of text");

	// No digit run survives into a block comment
	a_block_no_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_BLOCK) |-> !pend_q && (acc_q == '0))
		else $error("pending digits inside block comment");

	// End of text always closes with an end-of-track token
	a_eot_last_tok: assert property (@(posedge clk) disable iff (!arst_n)
		pair_load && eot |->
			((pair.cnt == 2'd1) && (pair.tok0.kind == mmlx_pkg::TK_END)) ||
			((pair.cnt == 2'd2) && (pair.tok1.kind == mmlx_pkg::TK_END)))
		else $error("end of text without end-of-track token");

endmodule

// ===== rtl/mmlx_out_buf.sv =====
// ----------------------------------------------------------------------------
// MML lexer output buffer
// Holds the tokens of one item and presents them one per transfer.
// ----------------------------------------------------------------------------
module mmlx_out_buf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pair_load,
	input  mmlx_pkg::pair_t pair_in,
	output logic            pair_free,
	mmlx_tok_if.source      tokens
);

	logic [1:0]       cnt_q;
	mmlx_pkg::token_t tok0_q;
	mmlx_pkg::token_t tok1_q;
	logic             xfer;

	assign xfer      = tokens.valid && tokens.ready;
	assign pair_free = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && tokens.ready);

	// Track how many tokens remain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (pair_load) begin
			cnt_q <= pair_in.cnt;
		end else if (xfer) begin
			cnt_q <= (cnt_q == 2'd2) ? 2'd1 : 2'd0;
		end
	end

	// Load a new pair or shift the second token forward
	always_ff @(posedge clk) begin
		if (pair_load) begin
			tok0_q <= pair_in.tok0;
			tok1_q <= pair_in.tok1;
		end else if (xfer && (cnt_q == 2'd2)) begin
			tok0_q <= tok1_q;
		end
	end

	assign tokens.valid            = (cnt_q != 2'd0);
	assign tokens.token_kind       = tok0_q.kind;
	assign tokens.note_letter      = tok0_q.letter;
	assign tokens.number_value     = tok0_q.value;
	assign tokens.number_saturated = tok0_q.sat;
	assign tokens.last_of_run      = tok0_q.last;

	// With two tokens held, only the second closes the run
	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !tok0_q.last && tok1_q.last)
		else $error("bad last-of-run marks in held pair");

	// A single remaining token always closes the run
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) |-> tok0_q.last)
		else $error("final token lacks last-of-run");

	// Never overwrite tokens that are still waiting
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		pair_load |-> (cnt_q == 2'd0) || ((cnt_q == 2'd1) && xfer))
		else $error("token pair overwritten before transfer");

endmodule

// ===== rtl/mml_character_lexer_core.sv =====
// ----------------------------------------------------------------------------
// MML character lexer core
// Streaming lexer for music macro language text, one character per clock while tokens keeps up.
// ----------------------------------------------------------------------------
// Usage:
//   text   : valid/ready sink of char_code (8-bit Latin-1) and end_of_text.
//            With end_of_text set the character is ignored; pending digits
//            are flushed and an end-of-track token closes the text.
//   tokens : valid/ready source of token_kind, note_letter, number_value,
//            number_saturated and last_of_run (set on the final token that
//            one input item causes).
//   Flow: a character is registered in the input register on transfer, and its
//   tokens are registered in the output buffer once that buffer is free; the
//   first token can then transfer. Throughput is one character per cycle
//   while tokens is ready; an item that yields two tokens holds the output
//   until both transfer, the single token register pair draining one per transfer.
//   Reset (arst_n low) empties both registers and returns the scanner to
//   normal mode with no pending number.
//   When tokens is stalled, the held tokens stay put; the next item that yields
//   tokens waits in the input register and text.ready drops once that register is full.
// ----------------------------------------------------------------------------
module mml_character_lexer_core #(
	parameter int VALUE_WIDTH = mmlx_pkg::VALUE_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mmlx_char_if.sink  text,
	mmlx_tok_if.source tokens
);

	logic            take;
	logic            item_valid;
	mmlx_pkg::item_t item;
	logic            pair_free;
	logic            pair_load;
	mmlx_pkg::pair_t pair;

	mmlx_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.text       (text),
		.take       (take),
		.item_valid (item_valid),
		.item       (item)
	);

	mmlx_lex #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_lex (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (take),
		.pair_free  (pair_free),
		.pair_load  (pair_load),
		.pair       (pair)
	);

	mmlx_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.pair_load (pair_load),
		.pair_in   (pair),
		.pair_free (pair_free),
		.tokens    (tokens)
	);

endmodule
